[design/tpdl_pkg.sv]
package tpdl_pkg;

  localparam int unsigned CFG_IDX_W   = 3;
  localparam int unsigned QUEUE_DEPTH = 4;
  // Widest rounded numerator magnitude is below 2^33, so the quotient needs 33 bits.
  localparam int unsigned QUO_W       = 33;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RAW_NEAR   = 3'd0,
    REG_RAW_MID    = 3'd1,
    REG_RAW_FAR    = 3'd2,
    REG_VALID_MASK = 3'd3,
    REG_GAP_NM     = 3'd4,
    REG_GAP_MF     = 3'd5,
    REG_OUTPUT_MAX = 3'd6
  } reg_idx_e;

  typedef enum logic [1:0] {
    MODE_INTERP,
    MODE_OFFSET,
    MODE_PASS
  } mode_e;

  typedef struct packed {
    logic [15:0] raw_near;
    logic [15:0] raw_mid;
    logic [15:0] raw_far;
    logic [2:0]  valid_mask;
    logic [15:0] gap_nm;
    logic [15:0] gap_mf;
    logic [15:0] output_max;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic [15:0]        raw;
    logic [15:0]        ra;
    logic [15:0]        span;
    logic signed [16:0] tdiff;
    logic signed [17:0] base;
  } item_t;

endpackage

[design/tpdl_front.sv]
module tpdl_front #(
  parameter int TARGET_NEAR_MM = 100,
  parameter int TARGET_MID_MM  = 300,
  parameter int TARGET_FAR_MM  = 500
) (
  input  tpdl_pkg::cfg_t  cfg_i,
  input  logic [15:0]     raw_distance_i,
  output tpdl_pkg::item_t item_o
);
  import tpdl_pkg::*;

  localparam logic signed [17:0] TN    = 18'(TARGET_NEAR_MM);
  localparam logic signed [17:0] TM    = 18'(TARGET_MID_MM);
  localparam logic signed [17:0] TF    = 18'(TARGET_FAR_MM);
  localparam logic signed [16:0] TD_NM = 17'(TARGET_MID_MM - TARGET_NEAR_MM);
  localparam logic signed [16:0] TD_MF = 17'(TARGET_FAR_MM - TARGET_MID_MM);
  localparam logic signed [16:0] TD_NF = 17'(TARGET_FAR_MM - TARGET_NEAR_MM);

  logic        has_n, has_m, has_f;
  logic        nm, mf, nf;
  logic [15:0] gap_nf;
  logic [15:0] span_nm, span_mf, span_nf;

  assign has_n   = cfg_i.valid_mask[0];
  assign has_m   = cfg_i.valid_mask[1];
  assign has_f   = cfg_i.valid_mask[2];
  assign gap_nf  = 16'(cfg_i.gap_nm + cfg_i.gap_mf);
  assign span_nm = 16'(cfg_i.raw_mid - cfg_i.raw_near);
  assign span_mf = 16'(cfg_i.raw_far - cfg_i.raw_mid);
  assign span_nf = 16'(cfg_i.raw_far - cfg_i.raw_near);

  assign nm = has_n && has_m && (cfg_i.raw_near < cfg_i.raw_mid) && (span_nm >= cfg_i.gap_nm);
  assign mf = has_m && has_f && (cfg_i.raw_mid < cfg_i.raw_far) && (span_mf >= cfg_i.gap_mf);
  assign nf = has_n && has_f && (cfg_i.raw_near < cfg_i.raw_far) && (span_nf >= gap_nf);

  always_comb begin
    item_o.mode  = MODE_PASS;
    item_o.raw   = raw_distance_i;
    item_o.ra    = cfg_i.raw_near;
    item_o.span  = span_nm;
    item_o.tdiff = TD_NM;
    item_o.base  = 18'({2'b00, raw_distance_i});
    if ((nm && (raw_distance_i <= cfg_i.raw_mid)) || (nm && !mf && !nf)) begin
      item_o.mode = MODE_INTERP;
      item_o.base = TN;
    end else if (mf && (raw_distance_i >= cfg_i.raw_mid)) begin
      item_o.mode  = MODE_INTERP;
      item_o.ra    = cfg_i.raw_mid;
      item_o.span  = span_mf;
      item_o.tdiff = TD_MF;
      item_o.base  = TM;
    end else if (nf) begin
      item_o.mode  = MODE_INTERP;
      item_o.span  = span_nf;
      item_o.tdiff = TD_NF;
      item_o.base  = TN;
    end else if (nm) begin
      item_o.mode = MODE_INTERP;
      item_o.base = TN;
    end else if (mf) begin
      item_o.mode  = MODE_INTERP;
      item_o.ra    = cfg_i.raw_mid;
      item_o.span  = span_mf;
      item_o.tdiff = TD_MF;
      item_o.base  = TM;
    end else if (has_m) begin
      item_o.mode = MODE_OFFSET;
      item_o.base = 18'({2'b00, raw_distance_i}) + TM - 18'({2'b00, cfg_i.raw_mid});
    end else if (has_n) begin
      item_o.mode = MODE_OFFSET;
      item_o.base = 18'({2'b00, raw_distance_i}) + TN - 18'({2'b00, cfg_i.raw_near});
    end else if (has_f) begin
      item_o.mode = MODE_OFFSET;
      item_o.base = 18'({2'b00, raw_distance_i}) + TF - 18'({2'b00, cfg_i.raw_far});
    end
  end

endmodule

[design/tpdl_queue.sv]
module tpdl_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tpdl_pkg::item_t push_item_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output tpdl_pkg::item_t pop_item_o
);
  import tpdl_pkg::*;

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  item_t            mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign full_o     = (count_q == CNT_W'(QUEUE_DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_item_o = mem_q[rd_ptr_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(wr_ptr_q + 1'b1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : PTR_W'(rd_ptr_q + 1'b1);
    end
    if (do_push && !do_pop) begin
      count_d = CNT_W'(count_q + 1'b1);
    end else if (do_pop && !do_push) begin
      count_d = CNT_W'(count_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH))
    else $error("queue count exceeds depth");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_push && !do_pop |=> count_q == CNT_W'($past(count_q) + 1'b1))
    else $error("queue count did not grow on push");

  a_pop_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    do_pop && !do_push |=> count_q == CNT_W'($past(count_q) - 1'b1))
    else $error("queue count did not shrink on pop");

endmodule

[design/tpdl_back.sv]
module tpdl_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic [15:0]     output_max_i,
  input  logic            empty_i,
  input  tpdl_pkg::item_t item_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [15:0]     corrected_distance_o,
  output logic            correction_ok_o
);
  import tpdl_pkg::*;

  typedef struct packed {
    mode_e              mode;
    logic signed [17:0] base;
    logic [15:0]        span;
    logic signed [16:0] dr;
    logic signed [16:0] tdiff;
  } mul_in_t;

  typedef struct packed {
    mode_e              mode;
    logic signed [17:0] base;
    logic [15:0]        span;
    logic signed [33:0] prod;
  } mul_out_t;

  typedef struct packed {
    mode_e              mode;
    logic               neg;
    logic signed [17:0] base;
    logic [15:0]        span;
    logic [15:0]        rem;
    logic [QUO_W-1:0]   num;
    logic [QUO_W-1:0]   quo;
  } div_t;

  function automatic div_t div_step(div_t s);
    div_t        r;
    logic [16:0] trial;
    r     = s;
    trial = {s.rem, s.num[QUO_W-1]};
    r.num = {s.num[QUO_W-2:0], 1'b0};
    if (trial >= {1'b0, s.span}) begin
      r.rem = 16'(trial - {1'b0, s.span});
      r.quo = {s.quo[QUO_W-2:0], 1'b1};
    end else begin
      r.rem = trial[15:0];
      r.quo = {s.quo[QUO_W-2:0], 1'b0};
    end
    return r;
  endfunction

  logic     adv;
  logic     a_vld_q, b_vld_q;
  mul_in_t  a_q, a_d;
  mul_out_t b_q, b_d;
  logic     dv_vld_q [QUO_W+1];
  div_t     dv_q     [QUO_W+1];
  div_t     c_d;
  logic [33:0] abs_prod;

  logic               out_valid_q;
  logic [15:0]        out_dist_q, out_dist_d;
  logic               out_ok_q, out_ok_d;
  logic signed [35:0] sq, val;

  assign adv   = !(out_valid_q && out_stall_i);
  assign pop_o = adv && !empty_i;

  always_comb begin
    a_d.mode  = item_i.mode;
    a_d.base  = item_i.base;
    a_d.span  = item_i.span;
    a_d.tdiff = item_i.tdiff;
    a_d.dr    = 17'({1'b0, item_i.raw}) - 17'({1'b0, item_i.ra});
  end

  always_comb begin
    b_d.mode = a_q.mode;
    b_d.base = a_q.base;
    b_d.span = a_q.span;
    b_d.prod = a_q.dr * a_q.tdiff;
  end

  always_comb begin
    abs_prod = b_q.prod[33] ? 34'(-b_q.prod) : b_q.prod;
    c_d.mode = b_q.mode;
    c_d.neg  = b_q.prod[33];
    c_d.base = b_q.base;
    c_d.span = b_q.span;
    c_d.rem  = '0;
    c_d.num  = QUO_W'(abs_prod[32:0]) + QUO_W'(b_q.span >> 1);
    c_d.quo  = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q     <= 1'b0;
      b_vld_q     <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i <= QUO_W; i++) begin
        dv_vld_q[i] <= 1'b0;
      end
    end else if (adv) begin
      a_vld_q     <= !empty_i;
      b_vld_q     <= a_vld_q;
      dv_vld_q[0] <= b_vld_q;
      for (int i = 0; i < QUO_W; i++) begin
        dv_vld_q[i+1] <= dv_vld_q[i];
      end
      out_valid_q <= dv_vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_q     <= a_d;
      b_q     <= b_d;
      dv_q[0] <= c_d;
      for (int i = 0; i < QUO_W; i++) begin
        dv_q[i+1] <= div_step(dv_q[i]);
      end
      out_dist_q <= out_dist_d;
      out_ok_q   <= out_ok_d;
    end
  end

  always_comb begin
    sq  = dv_q[QUO_W].neg ? -$signed({3'b000, dv_q[QUO_W].quo})
                          : $signed({3'b000, dv_q[QUO_W].quo});
    val = (dv_q[QUO_W].mode == MODE_INTERP) ? 36'(dv_q[QUO_W].base) + sq
                                            : 36'(dv_q[QUO_W].base);
    out_ok_d   = 1'b1;
    out_dist_d = val[15:0];
    case (dv_q[QUO_W].mode)
      MODE_INTERP, MODE_OFFSET: begin
        if (val < 0) begin
          out_dist_d = '0;
        end else if (val > $signed({20'b0, output_max_i})) begin
          out_dist_d = output_max_i;
        end
      end
      MODE_PASS: begin
        out_ok_d   = 1'b0;
        out_dist_d = dv_q[QUO_W].base[15:0];
      end
      default: begin
        out_ok_d   = 1'b0;
        out_dist_d = dv_q[QUO_W].base[15:0];
      end
    endcase
  end

  assign out_valid_o          = out_valid_q;
  assign corrected_distance_o = out_dist_q;
  assign correction_ok_o      = out_ok_q;

  a_rem_below_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_vld_q[QUO_W] && (dv_q[QUO_W].mode == MODE_INTERP) |->
      dv_q[QUO_W].rem < dv_q[QUO_W].span)
    else $error("divider remainder not below divisor");

  a_pop_only_when_moving: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> adv && !empty_i)
    else $error("queue popped while back end is held");

  a_hold_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> $stable(dv_vld_q[QUO_W]) && $stable(b_vld_q))
    else $error("back pipeline moved while output stalled");

endmodule

[design/three_point_distance_linearizer.sv]
// Three-point distance linearizer.
// Input channel: raw_distance_i with in_valid_i / in_stall_o; a word is taken at
// a rising edge with valid high and stall low. Output channel: corrected_distance_o
// and correction_ok_o with out_valid_o / out_stall_i, same rule.
// Calibration registers are written through cfg_valid_i / cfg_ready_o with
// cfg_index_i selecting the register and cfg_data_i the value; ready is always
// high and an index above six is ignored. Write them only while the block is idle.
// Throughput is one word per cycle while the receiver does not stall. From input accept
// to output valid a word passes through one queue slot, a subtract stage, a 17x17
// multiply stage, a rounding stage, a 33-stage one-bit-per-stage restoring divider
// and the output register. The divider pipeline depth sets the latency.
// When the receiver stalls, the whole back pipeline holds; the four-word queue
// between classifier and back end keeps taking words until it is full, and then
// in_stall_o rises.
// Reset clears the pipeline and the queue and loads the calibration registers
// with their defaults: points 100, 300, 500, no valid point, zero gaps, maximum 9999.
module three_point_distance_linearizer #(
  parameter int TARGET_NEAR_MM = 100,
  parameter int TARGET_MID_MM  = 300,
  parameter int TARGET_FAR_MM  = 500
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [15:0]                    raw_distance_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [15:0]                    corrected_distance_o,
  output logic                           correction_ok_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tpdl_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [15:0]                    cfg_data_i
);
  import tpdl_pkg::*;

  cfg_t  cfg_q;
  item_t front_item, queue_item;
  logic  queue_full, queue_empty, queue_pop;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_near   <= 16'd100;
      cfg_q.raw_mid    <= 16'd300;
      cfg_q.raw_far    <= 16'd500;
      cfg_q.valid_mask <= 3'd0;
      cfg_q.gap_nm     <= 16'd0;
      cfg_q.gap_mf     <= 16'd0;
      cfg_q.output_max <= 16'd9999;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_RAW_NEAR:   cfg_q.raw_near   <= cfg_data_i;
        REG_RAW_MID:    cfg_q.raw_mid    <= cfg_data_i;
        REG_RAW_FAR:    cfg_q.raw_far    <= cfg_data_i;
        REG_VALID_MASK: cfg_q.valid_mask <= cfg_data_i[2:0];
        REG_GAP_NM:     cfg_q.gap_nm     <= cfg_data_i;
        REG_GAP_MF:     cfg_q.gap_mf     <= cfg_data_i;
        REG_OUTPUT_MAX: cfg_q.output_max <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tpdl_front #(
    .TARGET_NEAR_MM(TARGET_NEAR_MM),
    .TARGET_MID_MM (TARGET_MID_MM),
    .TARGET_FAR_MM (TARGET_FAR_MM)
  ) u_front (
    .cfg_i         (cfg_q),
    .raw_distance_i(raw_distance_i),
    .item_o        (front_item)
  );

  assign in_stall_o = queue_full;

  tpdl_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_item_i(front_item),
    .full_o     (queue_full),
    .pop_i      (queue_pop),
    .empty_o    (queue_empty),
    .pop_item_o (queue_item)
  );

  tpdl_back u_back (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .output_max_i        (cfg_q.output_max),
    .empty_i             (queue_empty),
    .item_i              (queue_item),
    .pop_o               (queue_pop),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .corrected_distance_o(corrected_distance_o),
    .correction_ok_o     (correction_ok_o)
  );

endmodule

[tb/tb_three_point_distance_linearizer.sv]
module tb_three_point_distance_linearizer;
  timeunit 1ns;
  timeprecision 1ps;

  import tpdl_pkg::*;

  localparam int TGT_NEAR = 100;
  localparam int TGT_MID  = 300;
  localparam int TGT_FAR  = 500;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;
  localparam int LATENCY_CYCLES = 40;
  localparam int MAX_REPORTS    = 40;

  typedef struct {
    logic [15:0] raw;
    logic [15:0] distance;
    logic        ok;
  } reading_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_stall_o;
  logic [15:0]          raw_distance_i = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  logic [15:0]          corrected_distance_o;
  logic                 correction_ok_o;
  logic                 cfg_valid_i = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = '0;
  logic [15:0]          cfg_data_i = '0;

  cfg_t        cal;
  logic [15:0] pending_raw[$];
  reading_t    expected_readings[$];
  int unsigned error_count = 0;
  bit          idle_en = 1'b1;
  int          gap_left = 0;
  int          stall_left = 0;

  three_point_distance_linearizer #(
    .TARGET_NEAR_MM(TGT_NEAR),
    .TARGET_MID_MM (TGT_MID),
    .TARGET_FAR_MM (TGT_FAR)
  ) dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .in_stall_o          (in_stall_o),
    .raw_distance_i      (raw_distance_i),
    .out_valid_o         (out_valid_o),
    .out_stall_i         (out_stall_i),
    .corrected_distance_o(corrected_distance_o),
    .correction_ok_o     (correction_ok_o),
    .cfg_valid_i         (cfg_valid_i),
    .cfg_ready_o         (cfg_ready_o),
    .cfg_index_i         (cfg_index_i),
    .cfg_data_i          (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int pick_idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 93) return $urandom_range(1, 3);
    if (r < 99) return $urandom_range(4, 15);
    return $urandom_range(30, 80);
  endfunction

  function automatic logic [15:0] clamp_distance(longint v);
    longint top;
    top = cal.output_max;
    if (v < 0) return 16'd0;
    if (v > top) return cal.output_max;
    return v[15:0];
  endfunction

  function automatic logic pair_qualifies(logic [15:0] ra, logic [15:0] rb, logic [15:0] gap);
    return (ra < rb) && (16'(rb - ra) >= gap);
  endfunction

  function automatic logic [15:0] interp_segment(logic [15:0] raw, logic [15:0] ra, longint ta,
                                                 logic [15:0] rb, longint tb);
    longint raw_l, ra_l, rb_l, span, num;
    raw_l = raw;
    ra_l  = ra;
    rb_l  = rb;
    span  = rb_l - ra_l;
    num   = (raw_l - ra_l) * (tb - ta);
    if (num >= 0) num = num + span / 2;
    else num = num - span / 2;
    return clamp_distance(ta + num / span);
  endfunction

  function automatic logic [15:0] offset_point(logic [15:0] raw, logic [15:0] rp, longint t);
    longint raw_l, rp_l;
    raw_l = raw;
    rp_l  = rp;
    return clamp_distance(raw_l + (t - rp_l));
  endfunction

  function automatic reading_t predict_reading(logic [15:0] raw);
    reading_t    rd;
    logic        has_n, has_m, has_f, nm_ok, mf_ok, nf_ok;
    logic [15:0] gap_nf;
    rd.raw = raw;
    rd.ok  = 1'b1;
    has_n  = cal.valid_mask[0];
    has_m  = cal.valid_mask[1];
    has_f  = cal.valid_mask[2];
    gap_nf = cal.gap_nm + cal.gap_mf;
    nm_ok  = has_n && has_m && pair_qualifies(cal.raw_near, cal.raw_mid, cal.gap_nm);
    mf_ok  = has_m && has_f && pair_qualifies(cal.raw_mid, cal.raw_far, cal.gap_mf);
    nf_ok  = has_n && has_f && pair_qualifies(cal.raw_near, cal.raw_far, gap_nf);
    if (nm_ok && raw <= cal.raw_mid) begin
      rd.distance = interp_segment(raw, cal.raw_near, TGT_NEAR, cal.raw_mid, TGT_MID);
    end else if (mf_ok && raw >= cal.raw_mid) begin
      rd.distance = interp_segment(raw, cal.raw_mid, TGT_MID, cal.raw_far, TGT_FAR);
    end else if (nf_ok) begin
      rd.distance = interp_segment(raw, cal.raw_near, TGT_NEAR, cal.raw_far, TGT_FAR);
    end else if (nm_ok) begin
      rd.distance = interp_segment(raw, cal.raw_near, TGT_NEAR, cal.raw_mid, TGT_MID);
    end else if (mf_ok) begin
      rd.distance = interp_segment(raw, cal.raw_mid, TGT_MID, cal.raw_far, TGT_FAR);
    end else if (has_m) begin
      rd.distance = offset_point(raw, cal.raw_mid, TGT_MID);
    end else if (has_n) begin
      rd.distance = offset_point(raw, cal.raw_near, TGT_NEAR);
    end else if (has_f) begin
      rd.distance = offset_point(raw, cal.raw_far, TGT_FAR);
    end else begin
      rd.distance = raw;
      rd.ok       = 1'b0;
    end
    return rd;
  endfunction

  task automatic report_mismatch(string msg);
    if (error_count < MAX_REPORTS) $display("%0t mismatch: %s", $realtime, msg);
    error_count++;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_RAW_NEAR:   cal.raw_near   = val;
      REG_RAW_MID:    cal.raw_mid    = val;
      REG_RAW_FAR:    cal.raw_far    = val;
      REG_VALID_MASK: cal.valid_mask = val[2:0];
      REG_GAP_NM:     cal.gap_nm     = val;
      REG_GAP_MF:     cal.gap_mf     = val;
      REG_OUTPUT_MAX: cal.output_max = val;
      default: ;
    endcase
  endtask

  // The last write targets an unmapped index, which must leave every register alone.
  task automatic program_cal(logic [15:0] near, logic [15:0] mid, logic [15:0] far,
                             logic [2:0] mask, logic [15:0] gnm, logic [15:0] gmf,
                             logic [15:0] omax);
    write_reg(REG_RAW_NEAR, near);
    write_reg(REG_RAW_MID, mid);
    write_reg(REG_RAW_FAR, far);
    write_reg(REG_VALID_MASK, {13'($urandom), mask});
    write_reg(REG_GAP_NM, gnm);
    write_reg(REG_GAP_MF, gmf);
    write_reg(REG_OUTPUT_MAX, omax);
    write_reg(REG_UNMAPPED, 16'($urandom));
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    while (pending_raw.size() != 0 || in_valid_i || expected_readings.size() != 0)
      @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      raw_distance_i <= '0;
      gap_left = 0;
    end else begin
      if (in_valid_i && !in_stall_o) expected_readings.push_back(predict_reading(raw_distance_i));
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_raw.size() != 0) begin
          in_valid_i     <= 1'b1;
          raw_distance_i <= pending_raw.pop_front();
          gap_left = idle_en ? pick_idle_len() : 0;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_readings.size() == 0) begin
          report_mismatch($sformatf("unexpected word distance=%0d ok=%0b",
                                    corrected_distance_o, correction_ok_o));
        end else begin
          want = expected_readings.pop_front();
          if (corrected_distance_o !== want.distance)
            report_mismatch($sformatf("raw=%0d distance got %0d want %0d",
                                      want.raw, corrected_distance_o, want.distance));
          if (correction_ok_o !== want.ok)
            report_mismatch($sformatf("raw=%0d ok got %0b want %0b",
                                      want.raw, correction_ok_o, want.ok));
        end
      end
      if (stall_left == 0 && idle_en) stall_left = pick_idle_len();
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin
    #(64'd10_000_000);
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    logic [15:0] near, mid, far, gnm, gmf, omax, pt;
    logic [2:0]  mask;
    int          n, r;
    cal = '{raw_near: 16'd100, raw_mid: 16'd300, raw_far: 16'd500, valid_mask: 3'd0,
            gap_nm: 16'd0, gap_mf: 16'd0, output_max: 16'd9999};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    pending_raw = '{16'd0, 16'd65535, 16'd12345};
    drain();
    program_cal(100, 300, 500, 3'd7, 0, 0, 9999);
    pending_raw = '{16'd0, 16'd100, 16'd300, 16'd301, 16'd500, 16'd65535};
    drain();
    program_cal(10, 13, 40000, 3'd7, 0, 0, 9999);
    pending_raw = '{16'd9, 16'd11, 16'd12};
    drain();
    program_cal(1000, 1400, 1800, 3'd3, 0, 0, 65535);
    pending_raw = '{16'd999, 16'd1001, 16'd65535};
    drain();
    program_cal(100, 300, 900, 3'd7, 65535, 601, 9999);
    pending_raw = '{16'd250, 16'd2000};
    drain();
    program_cal(100, 300, 500, 3'd6, 0, 0, 9999);
    pending_raw = '{16'd50};
    drain();
    program_cal(500, 300, 100, 3'd7, 0, 0, 9999);
    pending_raw = '{16'd1000};
    drain();
    program_cal(500, 300, 100, 3'd1, 0, 0, 9999);
    pending_raw = '{16'd100, 16'd1000};
    drain();
    program_cal(500, 300, 100, 3'd4, 0, 0, 0);
    pending_raw = '{16'd1000};
    drain();
    program_cal(100, 300, 500, 3'd5, 0, 0, 9999);
    pending_raw = '{16'd200};
    drain();
    program_cal(300, 300, 300, 3'd7, 0, 0, 9999);
    pending_raw = '{16'd300};
    drain();

    for (int ph = 0; ph < 24; ph++) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        near = 16'($urandom_range(0, 20000));
        mid  = near + 16'($urandom_range(1, 20000));
        far  = mid + 16'($urandom_range(1, 20000));
      end else if (r < 8) begin
        near = 16'($urandom_range(0, 60000));
        mid  = near + 16'($urandom_range(1, 4));
        far  = mid + 16'($urandom_range(1, 4));
      end else begin
        near = 16'($urandom);
        mid  = 16'($urandom);
        far  = 16'($urandom);
      end
      mask = ($urandom_range(0, 1) == 0) ? 3'd7 : 3'($urandom_range(0, 7));
      case ($urandom_range(0, 3))
        0: gnm = 16'd0;
        1: gnm = mid - near;
        2: gnm = mid - near + 16'd1;
        default: gnm = 16'($urandom);
      endcase
      case ($urandom_range(0, 3))
        0: gmf = 16'd0;
        1: gmf = far - mid;
        2: gmf = far - mid + 16'd1;
        default: gmf = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
        0: omax = 16'd0;
        1: omax = 16'd65535;
        2, 3, 4: omax = 16'd9999;
        default: omax = 16'($urandom);
      endcase
      program_cal(near, mid, far, mask, gnm, gmf, omax);
      idle_en = (ph % 6 != 3);
      n = $urandom_range(40, 80);
      repeat (n) begin
        r = $urandom_range(0, 9);
        case ($urandom_range(0, 2))
          0: pt = near;
          1: pt = mid;
          default: pt = far;
        endcase
        if (r < 4) pending_raw.push_back(16'($urandom));
        else if (r < 8) pending_raw.push_back(pt + 16'($urandom_range(0, 64)) - 16'd32);
        else if (r < 9) pending_raw.push_back(pt);
        else pending_raw.push_back(($urandom_range(0, 1) == 0) ? 16'd0 : 16'd65535);
      end
      drain();
    end

    repeat (LATENCY_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
